/* hdl/atrl_pkg.sv */
// Shared constants, types and character helpers for the AT reply line recognizer.
`timescale 1ns / 1ps
`default_nettype none

package atrl_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int TEXT_DEPTH = 64;

  localparam int TEXT_AW = $clog2(TEXT_DEPTH);
  localparam int TEXT_CW = $clog2(TEXT_DEPTH + 1);
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int POS_W   = (TEXT_CW > LINE_AW) ? TEXT_CW : LINE_AW;

  // Commands on the input tuser
  localparam logic [1:0] CMD_STOP   = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_ARM    = 2'd2;
  localparam logic [1:0] CMD_BYTE   = 2'd3;

  // Parse modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ECHO    = 2'd1;
  localparam logic [1:0] MODE_WAITEOL = 2'd2;
  localparam logic [1:0] MODE_REPLY   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_OK    = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  // Bytes below this value are control characters
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  localparam int OK_LEN  = 2;
  localparam int ERR_LEN = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line_byte;
    logic       last;
    logic       trunc;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [TEXT_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [TEXT_AW-1:0] raddr;
  } text_req_t;

  typedef struct packed {
    logic               we;
    logic [LINE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [LINE_AW-1:0] raddr;
  } line_req_t;

  function automatic logic [7:0] ok_char(input logic sel);
    logic [7:0] ch;
    ch = sel ? 8'h4B : 8'h4F;
    return ch;
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] sel);
    logic [7:0] ch;
    case (sel)
      3'd0:    ch = 8'h45;
      3'd1:    ch = 8'h52;
      3'd2:    ch = 8'h52;
      3'd3:    ch = 8'h4F;
      3'd4:    ch = 8'h52;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* hdl/atrl_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module atrl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/atrl_seq.sv */
// Sequencer with the shared byte compare unit: echo match, line collect, classify, emit.
`timescale 1ns / 1ps
`default_nettype none

module atrl_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,
  input  wire logic [1:0]         s_tuser,
  input  wire logic               s_tlast,
  output atrl_pkg::text_req_t     text_req,
  input  wire logic [7:0]         text_rdata,
  output atrl_pkg::line_req_t     line_req,
  input  wire logic [7:0]         line_rdata,
  input  wire logic               out_free,
  output logic                    push,
  output atrl_pkg::result_t       res
);
  import atrl_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ARM      = 4'd1;
  localparam logic [3:0] S_ECHO_CMP = 4'd2;
  localparam logic [3:0] S_ECHO_END = 4'd3;
  localparam logic [3:0] S_CLS_RD   = 4'd4;
  localparam logic [3:0] S_CLS_CMP  = 4'd5;
  localparam logic [3:0] S_DECIDE   = 4'd6;
  localparam logic [3:0] S_FIN      = 4'd7;
  localparam logic [3:0] S_EMIT_RD  = 4'd8;
  localparam logic [3:0] S_EMIT_WR  = 4'd9;

  logic [3:0]         state, state_next;
  logic [1:0]         mode, mode_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [TEXT_CW-1:0] exp_len, exp_len_next;
  logic               ovf, ovf_next;
  logic               skip, skip_next;

  logic [7:0]         c_q, c_next;
  logic               end_q, end_next;
  logic [LINE_AW-1:0] line_len, line_len_next;
  logic [LINE_AW-1:0] idx, idx_next;
  logic               okm, okm_next;
  logic               errm, errm_next;
  logic               trunc, trunc_next;

  logic [POS_W-1:0]   pos_inc;
  logic [LINE_AW-1:0] scan_last;
  logic               is_ok;
  logic               is_err;
  logic               idx_at_end;

  assign pos_inc    = pos + POS_W'(1);
  assign scan_last  = (line_len < LINE_AW'(ERR_LEN)) ? (line_len - LINE_AW'(1))
                                                     : LINE_AW'(ERR_LEN - 1);
  assign is_ok      = (line_len == LINE_AW'(OK_LEN)) && okm;
  assign is_err     = (line_len >= LINE_AW'(ERR_LEN)) && errm;
  assign idx_at_end = (idx == line_len - LINE_AW'(1));
  assign s_tready   = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    pos_next      = pos;
    exp_len_next  = exp_len;
    ovf_next      = ovf;
    skip_next     = skip;
    c_next        = c_q;
    end_next      = end_q;
    line_len_next = line_len;
    idx_next      = idx;
    okm_next      = okm;
    errm_next     = errm;
    trunc_next    = trunc;

    text_req.we    = 1'b0;
    text_req.waddr = exp_len[TEXT_AW-1:0];
    text_req.wdata = s_tdata;
    text_req.raddr = pos[TEXT_AW-1:0];
    line_req.we    = 1'b0;
    line_req.waddr = pos[LINE_AW-1:0];
    line_req.wdata = s_tdata;
    line_req.raddr = idx;

    push          = 1'b0;
    res.kind      = KIND_LINE;
    res.line_byte = line_rdata;
    res.last      = idx_at_end;
    res.trunc     = trunc;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          c_next   = s_tdata;
          end_next = s_tlast;
          case (s_tuser)
            CMD_STOP: begin
              mode_next    = MODE_IDLE;
              pos_next     = '0;
              exp_len_next = '0;
            end
            CMD_APPEND: begin
              if (exp_len < TEXT_CW'(TEXT_DEPTH)) begin
                text_req.we  = 1'b1;
                exp_len_next = exp_len + TEXT_CW'(1);
              end
            end
            CMD_ARM: begin
              pos_next       = '0;
              ovf_next       = 1'b0;
              text_req.raddr = '0;
              state_next     = S_ARM;
            end
            CMD_BYTE: begin
              if (skip) begin
                if (s_tlast) begin
                  skip_next = 1'b0;
                end
              end else begin
                case (mode)
                  MODE_ECHO: begin
                    if (pos < POS_W'(exp_len)) begin
                      state_next = S_ECHO_CMP;
                    end else begin
                      pos_next = '0;
                    end
                  end
                  MODE_WAITEOL: begin
                    if (s_tdata < CTRL_LIMIT) begin
                      mode_next = MODE_REPLY;
                      pos_next  = '0;
                      ovf_next  = 1'b0;
                    end
                  end
                  MODE_REPLY: begin
                    if (s_tdata < CTRL_LIMIT) begin
                      if (pos != '0) begin
                        line_len_next = pos[LINE_AW-1:0];
                        trunc_next    = ovf;
                        pos_next      = '0;
                        ovf_next      = 1'b0;
                        idx_next      = '0;
                        okm_next      = 1'b1;
                        errm_next     = 1'b1;
                        state_next    = S_CLS_RD;
                      end
                    end else if (pos < POS_W'(LINE_DEPTH - 1)) begin
                      line_req.we = 1'b1;
                      pos_next    = pos_inc;
                    end else begin
                      ovf_next = 1'b1;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ARM: begin
        if ((exp_len == '0) || (text_rdata < CTRL_LIMIT)) begin
          mode_next = MODE_WAITEOL;
        end else begin
          mode_next = MODE_ECHO;
        end
        state_next = S_IDLE;
      end

      S_ECHO_CMP: begin
        if (text_rdata == c_q) begin
          pos_next       = pos_inc;
          text_req.raddr = pos_inc[TEXT_AW-1:0];
          state_next     = S_ECHO_END;
        end else begin
          // restart matching; this byte is not compared again
          pos_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_ECHO_END: begin
        if ((pos >= POS_W'(exp_len)) || (text_rdata < CTRL_LIMIT)) begin
          mode_next = MODE_WAITEOL;
          pos_next  = '0;
        end
        state_next = S_IDLE;
      end

      S_CLS_RD: begin
        state_next = S_CLS_CMP;
      end

      S_CLS_CMP: begin
        okm_next  = okm && (line_rdata == ok_char(idx[0]));
        errm_next = errm && (line_rdata == err_char(idx[2:0]));
        if (idx == scan_last) begin
          state_next = S_DECIDE;
        end else begin
          idx_next   = idx + LINE_AW'(1);
          state_next = S_CLS_RD;
        end
      end

      S_DECIDE: begin
        if (is_ok || is_err) begin
          state_next = S_FIN;
        end else begin
          idx_next   = '0;
          state_next = S_EMIT_RD;
        end
      end

      S_FIN: begin
        res.kind      = is_ok ? KIND_OK : KIND_ERROR;
        res.line_byte = 8'd0;
        res.last      = 1'b1;
        if (out_free) begin
          push = 1'b1;
          // drop the rest of this chunk
          if (!end_q) begin
            skip_next = 1'b1;
          end
          state_next = S_IDLE;
        end
      end

      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (out_free) begin
          push = 1'b1;
          if (idx_at_end) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + LINE_AW'(1);
            state_next = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mode    <= MODE_IDLE;
      pos     <= '0;
      exp_len <= '0;
      ovf     <= 1'b0;
      skip    <= 1'b0;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      pos     <= pos_next;
      exp_len <= exp_len_next;
      ovf     <= ovf_next;
      skip    <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    c_q      <= c_next;
    end_q    <= end_next;
    line_len <= line_len_next;
    idx      <= idx_next;
    okm      <= okm_next;
    errm     <= errm_next;
    trunc    <= trunc_next;
  end

endmodule

`default_nettype wire

/* hdl/atrl_outreg.sv */
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module atrl_outreg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  atrl_pkg::result_t      res,
  output logic                   free,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,
  output logic [2:0]             m_tuser,
  output logic                   m_tlast
);
  import atrl_pkg::*;

  result_t held;

  assign free     = !m_tvalid || m_tready;
  assign m_tdata  = held.line_byte;
  assign m_tuser  = {held.trunc, held.kind};
  assign m_tlast  = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

/* hdl/at_reply_line_recognizer_core.sv */
// Top level of the AT reply line recognizer: sequencer, text and line stores, output register.
// Stop and append are done in idle; arm passes an arm state that reads the text store; a serial
// byte in echo match passes a compare and, on a match, an end check state. A line end reads and
// compares each classified byte (up to 5), decides, then reads and writes each emitted byte, or
// writes one ok or error result; a stalled output holds the sequencer in its write state.
// Reset is synchronous and clears control state; text and line stores are left unwritten.
`timescale 1ns / 1ps
`default_nettype none

module at_reply_line_recognizer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // data_byte
  input  wire logic [1:0] s_tuser,   // command
  input  wire logic       s_tlast,   // chunk_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // line_byte
  output logic [2:0]      m_tuser,   // kind [1:0], line_truncated [2]
  output logic            m_tlast    // last
);
  import atrl_pkg::*;

  text_req_t  text_req;
  line_req_t  line_req;
  logic [7:0] text_rdata;
  logic [7:0] line_rdata;
  logic       out_free;
  logic       push;
  result_t    res;

  atrl_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .text_req   (text_req),
    .text_rdata (text_rdata),
    .line_req   (line_req),
    .line_rdata (line_rdata),
    .out_free   (out_free),
    .push       (push),
    .res        (res)
  );

  atrl_ram #(.DEPTH(TEXT_DEPTH), .WIDTH(8)) u_text_ram (
    .clk   (clk),
    .we    (text_req.we),
    .waddr (text_req.waddr),
    .wdata (text_req.wdata),
    .raddr (text_req.raddr),
    .rdata (text_rdata)
  );

  atrl_ram #(.DEPTH(LINE_DEPTH), .WIDTH(8)) u_line_ram (
    .clk   (clk),
    .we    (line_req.we),
    .waddr (line_req.waddr),
    .wdata (line_req.wdata),
    .raddr (line_req.raddr),
    .rdata (line_rdata)
  );

  atrl_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* hdl/atrl_checker.sv */
// Port-level checks for the AT reply line recognizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module atrl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [1:0] s_tuser,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [2:0] m_tuser,
  input wire logic       m_tlast
);
  import atrl_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != KIND_LINE) |-> (m_tdata == 8'd0) && m_tlast)
    else $error("ok or error result carries data or lacks last");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] == KIND_OK) || (m_tuser[1:0] == KIND_ERROR) ||
                 (m_tuser[1:0] == KIND_LINE))
    else $error("result kind out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not quiet after reset");

  a_stop_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_STOP) |=> s_tready)
    else $error("stop command held the input");

endmodule

bind at_reply_line_recognizer_core atrl_checker u_atrl_checker (.*);

`default_nettype wire

/* sim/at_reply_line_recognizer_core_tb.sv */
// Self-checking testbench for the AT reply line recognizer core.
`timescale 1ns / 1ps

module at_reply_line_recognizer_core_tb;
  import atrl_pkg::*;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 36;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // data_byte
  logic [1:0] s_tuser;   // command
  logic       s_tlast;   // chunk_end
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // line_byte
  logic [2:0] m_tuser;   // kind [1:0], line_truncated [2]
  logic       m_tlast;   // last

  at_reply_line_recognizer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted recognizer state
  logic [1:0] pr_mode;
  int         pr_pos;
  int         pr_text_len;
  logic [7:0] pr_text [TEXT_DEPTH];
  logic [7:0] pr_line [LINE_DEPTH];
  logic       pr_overflow;
  logic       pr_skip;

  result_t    pending_replies [$];
  logic [7:0] text_bytes [$];
  logic [7:0] line_bytes [$];

  int gap_pct;
  int stall_pct;
  int requests_sent;
  int replies_seen;
  int mismatches;
  int ok_seen;
  int error_seen;
  int line_seen;
  int trunc_seen;

  result_t want;
  result_t got;

  function automatic void queue_reply(input logic [1:0] kind, input logic [7:0] ch,
                                      input logic last, input logic trunc);
    result_t r;
    r.kind      = kind;
    r.line_byte = ch;
    r.last      = last;
    r.trunc     = trunc;
    pending_replies.push_back(r);
  endfunction

  function automatic bit text_done(input int idx);
    if (idx >= pr_text_len || idx >= TEXT_DEPTH) return 1'b1;
    return pr_text[idx] < CTRL_LIMIT;
  endfunction

  // Classify the stored line; returns 1 on an ok or error reply.
  function automatic bit close_reply_line();
    int   len;
    int   i;
    logic trunc;
    len   = pr_pos;
    trunc = pr_overflow;
    if (len == 0) return 1'b0;
    if (len > LINE_DEPTH - 1) len = LINE_DEPTH - 1;
    pr_pos      = 0;
    pr_overflow = 1'b0;
    if (len == OK_LEN && pr_line[0] == "O" && pr_line[1] == "K") begin
      queue_reply(KIND_OK, 8'h00, 1'b1, trunc);
      return 1'b1;
    end
    if (len >= ERR_LEN && pr_line[0] == "E" && pr_line[1] == "R" && pr_line[2] == "R" &&
        pr_line[3] == "O" && pr_line[4] == "R") begin
      queue_reply(KIND_ERROR, 8'h00, 1'b1, trunc);
      return 1'b1;
    end
    for (i = 0; i < len; i++)
      queue_reply(KIND_LINE, pr_line[i], i + 1 == len, trunc);
    return 1'b0;
  endfunction

  function automatic void predict_replies(input logic [1:0] cmd, input logic [7:0] ch,
                                          input logic chunk_end);
    bit final_reply;
    final_reply = 1'b0;
    case (cmd)
      CMD_STOP: begin
        pr_mode     = MODE_IDLE;
        pr_pos      = 0;
        pr_text_len = 0;
      end
      CMD_APPEND: begin
        if (pr_text_len < TEXT_DEPTH) begin
          pr_text[pr_text_len] = ch;
          pr_text_len++;
        end
      end
      CMD_ARM: begin
        pr_pos      = 0;
        pr_overflow = 1'b0;
        pr_mode     = text_done(0) ? MODE_WAITEOL : MODE_ECHO;
      end
      default: begin
        if (pr_skip) begin
          if (chunk_end) pr_skip = 1'b0;
        end else begin
          case (pr_mode)
            MODE_ECHO: begin
              if (pr_pos < pr_text_len && pr_pos < TEXT_DEPTH && pr_text[pr_pos] == ch) begin
                pr_pos++;
                if (text_done(pr_pos)) begin
                  pr_mode = MODE_WAITEOL;
                  pr_pos  = 0;
                end
              end else begin
                pr_pos = 0;
              end
            end
            MODE_WAITEOL: begin
              if (ch < CTRL_LIMIT) begin
                pr_mode     = MODE_REPLY;
                pr_pos      = 0;
                pr_overflow = 1'b0;
              end
            end
            MODE_REPLY: begin
              if (ch < CTRL_LIMIT) begin
                final_reply = close_reply_line();
              end else if (pr_pos < LINE_DEPTH - 1) begin
                pr_line[pr_pos] = ch;
                pr_pos++;
              end else begin
                pr_overflow = 1'b1;
              end
            end
            default: ;
          endcase
          if (final_reply && !chunk_end) pr_skip = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.kind      = m_tuser[1:0];
      got.line_byte = m_tdata;
      got.last      = m_tlast;
      got.trunc     = m_tuser[2];
      replies_seen++;
      if (got.kind == KIND_OK) ok_seen++;
      if (got.kind == KIND_ERROR) error_seen++;
      if (got.kind == KIND_LINE) line_seen++;
      if (got.trunc) trunc_seen++;
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d byte %02h last %0d trunc %0d",
                                got.kind, got.line_byte, got.last, got.trunc));
      end else begin
        want = pending_replies.pop_front();
        if (got.kind !== want.kind || got.line_byte !== want.line_byte ||
            got.last !== want.last || got.trunc !== want.trunc)
          flag_mismatch($sformatf({"expected kind %0d byte %02h last %0d trunc %0d, ",
                                   "got kind %0d byte %02h last %0d trunc %0d"},
                                  want.kind, want.line_byte, want.last, want.trunc,
                                  got.kind, got.line_byte, got.last, got.trunc));
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Caller sits at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                             input logic chunk_end);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    s_tlast  <= chunk_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_replies(cmd, data, chunk_end);
    requests_sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been taken.
  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic load_command(input int len, input int ctrl_at);
    int         i;
    logic [7:0] ch;
    text_bytes.delete();
    send_request(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
    for (i = 0; i < len; i++) begin
      ch = (i == ctrl_at) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(33, 126));
      text_bytes.push_back(ch);
      send_request(CMD_APPEND, ch, 1'($urandom_range(0, 1)));
    end
    send_request(CMD_ARM, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Echo the held text up to its first control character.
  task automatic send_echo(input int corrupt_at);
    int         i;
    logic [7:0] ch;
    for (i = 0; i < text_bytes.size() && i < TEXT_DEPTH && text_bytes[i] >= CTRL_LIMIT;
         i++) begin
      ch = (i == corrupt_at) ? (text_bytes[i] ^ 8'h20) : text_bytes[i];
      send_request(CMD_BYTE, ch, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic send_line();
    int         i;
    logic [7:0] term;
    for (i = 0; i < line_bytes.size(); i++)
      send_request(CMD_BYTE, line_bytes[i], $urandom_range(0, 11) == 0);
    term = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31)) : CH_CR;
    send_request(CMD_BYTE, term, $urandom_range(0, 3) == 0);
    send_request(CMD_BYTE, CH_LF, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed_cases();
    send_request(CMD_BYTE, 8'hFF, 1'b1);   // idle: ignored
    send_request(CMD_ARM, 8'h00, 1'b0);    // empty text: straight to end of echo
    send_request(CMD_BYTE, "A", 1'b0);
    send_request(CMD_BYTE, CH_CR, 1'b0);
    send_request(CMD_BYTE, CH_LF, 1'b0);   // empty line
    send_request(CMD_BYTE, "O", 1'b0);
    send_request(CMD_BYTE, "K", 1'b0);
    send_request(CMD_BYTE, CH_CR, 1'b0);   // ok mid-chunk: skip the rest
    send_request(CMD_ARM, 8'hA5, 1'b1);    // skip flag survives arming
    send_request(CMD_BYTE, "Z", 1'b1);
    send_request(CMD_BYTE, CH_CR, 1'b0);
    send_request(CMD_BYTE, "E", 1'b0);
    send_request(CMD_BYTE, "R", 1'b0);
    send_request(CMD_BYTE, "R", 1'b0);
    send_request(CMD_BYTE, "O", 1'b0);
    send_request(CMD_BYTE, "R", 1'b0);
    send_request(CMD_BYTE, CH_CR, 1'b1);   // error at chunk end: no skip
    send_request(CMD_BYTE, "A", 1'b0);
    send_request(CMD_BYTE, 8'hFF, 1'b0);
    send_request(CMD_BYTE, CH_LF, 1'b0);
    send_request(CMD_STOP, 8'hFF, 1'b1);
    send_request(CMD_APPEND, "A", 1'b0);
    send_request(CMD_APPEND, "T", 1'b0);
    send_request(CMD_APPEND, CH_CR, 1'b0); // control char ends the text early
    send_request(CMD_ARM, 8'h00, 1'b0);
    send_request(CMD_BYTE, "A", 1'b0);
    send_request(CMD_BYTE, "X", 1'b0);     // mismatch: restart matching
    send_request(CMD_BYTE, "A", 1'b0);
    send_request(CMD_BYTE, "T", 1'b0);
  endtask

  // Overfill the text store, then overfill the line store.
  task automatic test_store_limits();
    load_command(TEXT_DEPTH + 1, -1);
    send_echo(-1);
    send_request(CMD_BYTE, CH_CR, 1'b0);
    line_bytes.delete();
    repeat (LINE_DEPTH + 2) line_bytes.push_back(8'($urandom_range(32, 255)));
    send_line();
  endtask

  task automatic run_reply_session();
    int sel;
    int len;
    int ctrl_at;
    int n_lines;
    sel     = $urandom_range(0, 19);
    len     = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    ctrl_at = ($urandom_range(0, 5) == 0 && len > 0) ? $urandom_range(0, len - 1) : -1;
    load_command(len, ctrl_at);
    if (len > 0 && $urandom_range(0, 4) == 0) send_echo($urandom_range(0, len - 1));
    send_echo(-1);
    send_request(CMD_BYTE, CH_CR, 1'b0);
    send_request(CMD_BYTE, CH_LF, 1'($urandom_range(0, 1)));
    n_lines = $urandom_range(1, 3);
    repeat (n_lines) begin
      line_bytes.delete();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = ($urandom_range(0, 29) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 12);
          repeat (len) line_bytes.push_back(8'($urandom_range(32, 255)));
        end
        4, 5: begin
          line_bytes.push_back("O");
          line_bytes.push_back("K");
        end
        6, 7: begin
          line_bytes = '{"E", "R", "R", "O", "R"};
          repeat ($urandom_range(0, 4)) line_bytes.push_back(8'($urandom_range(32, 126)));
        end
        8: begin
          case ($urandom_range(0, 2))
            0:       line_bytes = '{"O"};
            1:       line_bytes = '{"O", "K", "K"};
            default: line_bytes = '{"E", "R", "R", "O"};
          endcase
        end
        default: ;
      endcase
      send_line();
    end
  endtask

  task automatic test_random_sessions(input int sender_idle, input int receiver_stall);
    int start;
    gap_pct   = sender_idle;
    stall_pct = receiver_stall;
    start     = requests_sent;
    while (requests_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise: fully random requests
        repeat ($urandom_range(1, 3))
          send_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        run_reply_session();
      end
      if ($urandom_range(0, 19) == 0) wait_for_replies();
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tuser     = CMD_STOP;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    pr_mode     = MODE_IDLE;
    pr_pos      = 0;
    pr_text_len = 0;
    pr_overflow = 1'b0;
    pr_skip     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    wait_for_replies();
    test_store_limits();
    wait_for_replies();
    test_random_sessions(0, 0);
    wait_for_replies();
    test_random_sessions(51, 0);
    wait_for_replies();
    test_random_sessions(0, 51);
    wait_for_replies();
    test_random_sessions(30, 30);
    wait_for_replies();
    repeat (300) @(posedge clk);

    $display("Run covered %0d requests: directed cases, store limits, four idle/stall phases.",
             requests_sent);
    $display("Results taken: %0d (%0d ok, %0d error, %0d line bytes, %0d truncated), %0d bad.",
             replies_seen, ok_seen, error_seen, line_seen, trunc_seen, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("** at_reply_line_recognizer_core: PASSED **");
    end else begin
      $display("** at_reply_line_recognizer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending.", pending_replies.size());
    $display("** at_reply_line_recognizer_core: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
hdl/atrl_pkg.sv
hdl/atrl_ram.sv
hdl/atrl_seq.sv
hdl/atrl_outreg.sv
hdl/at_reply_line_recognizer_core.sv
hdl/atrl_checker.sv
sim/at_reply_line_recognizer_core_tb.sv
